// ----- hw/rtl/mfm_pkg.sv -----
// Shared types, constants and status codes for the model fit metrics engine.
package mfm_pkg;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned AGREE_W  = 17;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Queue entry between the front and back parts.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] observed;
      logic signed [SAMPLE_W-1:0] simulated;
      logic                       keep;
      logic                       last;
   } pair_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MEAN,
      ST_RMSE_DIV,
      ST_RMSE_SQRT,
      ST_NRMSE,
      ST_PASS,
      ST_PASS_MAC,
      ST_D_DIV,
      ST_DONE,
      ST_OUT
   } back_state_type;

endpackage

// ----- hw/rtl/model_fit_metrics_engine.sv -----
// Top level of the model fit metrics engine.
//   channel | direction | handshake        | payload
//   req_    | in        | valid / stall    | observed, simulated, pair_valid, last_pair
//   rsp_    | out       | valid / stall    | set_id, count, rms_error, nrmse, d, status
//   csr_    | in        | valid / ready    | treatment_id
// Loading waits after each stored pair until its squared term is in the sum.
// After the last pair: mean, RMSE and NRMSE divides through one shared
// bit-serial divider, a bit-serial root, a pass over the stores, and one
// more divide for d.
// Synchronous active-high reset clears control state; stores need no clearing.
// A stalled result holds the back part; the queue fills and stalls req_.
module model_fit_metrics_engine
   import mfm_pkg::*;
#(
   parameter int unsigned MAX_PAIRS = 1024,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_observed_sample,
   input  logic signed [SAMPLE_W-1:0] req_simulated_sample,
   input  logic                       req_pair_valid,
   input  logic                       req_last_pair,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ID_W-1:0]            rsp_set_id,
   output logic [COUNT_W-1:0]         rsp_valid_count,
   output logic [SAMPLE_W-1:0]        rsp_rms_error,
   output logic signed [SAMPLE_W-1:0] rsp_nrmse_percent,
   output logic [AGREE_W-1:0]         rsp_agreement_index,
   output logic [STATUS_W-1:0]        rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ID_W-1:0]            csr_treatment_id
);

   logic [ID_W-1:0] treatment_id_ff;
   logic            q_valid, q_pop;
   pair_type        q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         treatment_id_ff <= '0;
      end else if (csr_valid) begin
         treatment_id_ff <= csr_treatment_id;
      end
   end

   mfm_front #(.DEPTH(4)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_observed_sample(req_observed_sample),
      .req_simulated_sample(req_simulated_sample),
      .req_pair_valid(req_pair_valid), .req_last_pair(req_last_pair),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   mfm_back #(.MAX_PAIRS(MAX_PAIRS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .treatment_id(treatment_id_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_set_id(rsp_set_id), .rsp_valid_count(rsp_valid_count),
      .rsp_rms_error(rsp_rms_error), .rsp_nrmse_percent(rsp_nrmse_percent),
      .rsp_agreement_index(rsp_agreement_index), .rsp_status(rsp_status));

endmodule

// ----- hw/rtl/mfm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mfm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/mfm_front.sv -----
// Front part: accepts pairs, classifies them and feeds a short queue.
module mfm_front
   import mfm_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_observed_sample,
   input  logic signed [SAMPLE_W-1:0] req_simulated_sample,
   input  logic                       req_pair_valid,
   input  logic                       req_last_pair,
   output logic                       q_valid,
   output pair_type                   q_data,
   input  logic                       q_pop
);

   localparam int unsigned AW = $clog2(DEPTH);

   pair_type        entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     fill_ff, fill_in;
   logic            push;

   assign req_stall = (fill_ff == (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (AW+1)'(push) - (AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{observed: req_observed_sample,
                                  simulated: req_simulated_sample,
                                  keep: req_pair_valid,
                                  last: req_last_pair};
      end
   end

endmodule

// ----- hw/rtl/mfm_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module mfm_divider #(
   parameter int unsigned WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] q_ff, q_in, d_ff, d_in;
   logic [WIDTH:0]   r_ff, r_in, trial;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   assign quotient = q_ff;
   assign done     = done_ff;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[WIDTH-1:0], q_ff[WIDTH-1]};
      if (start) begin
         q_in    = dividend;
         d_in    = divisor;
         r_in    = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract if it fits
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

endmodule

// ----- hw/rtl/mfm_back.sv -----
// Back part: accumulates pairs, then runs mean, RMSE, NRMSE and Willmott d.
module mfm_back
   import mfm_pkg::*;
#(
   parameter int unsigned MAX_PAIRS = 1024,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pair_type             q_data,
   output logic                 q_pop,
   input  logic [ID_W-1:0]      treatment_id,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ID_W-1:0]      rsp_set_id,
   output logic [COUNT_W-1:0]   rsp_valid_count,
   output logic [SAMPLE_W-1:0]  rsp_rms_error,
   output logic [SAMPLE_W-1:0]  rsp_nrmse_percent,
   output logic [AGREE_W-1:0]   rsp_agreement_index,
   output logic [STATUS_W-1:0]  rsp_status
);

   localparam int unsigned AW  = $clog2(MAX_PAIRS);
   localparam int unsigned NW  = $clog2(MAX_PAIRS + 1);
   localparam int unsigned DW  = 128;
   localparam logic [AGREE_W-1:0] D_ONE = AGREE_W'(65536);
   // numerator scale for d is 2 * D_ONE, one extra bit for rounding
   localparam int unsigned D_SHIFT = 17;

   back_state_type state_ff, state_in;

   logic [NW-1:0]        n_ff;
   logic signed [63:0]   osum_ff;
   logic [63:0]          sqsum_ff;
   logic                 ovf_ff;
   logic signed [63:0]   mean_ff;
   logic [63:0]          smag;
   logic [31:0]          rmse_ff;
   logic [31:0]          sq_bit_ff;
   logic [63:0]          rdiv_ff;
   logic [31:0]          nrmse_ff;
   logic [DW-1:0]        den_ff;
   logic [AGREE_W-1:0]   d_ff;
   logic [NW-1:0]        idx_ff;
   logic                 rd_pend_ff;
   logic [1:0]           mac_ph_ff;
   logic [32:0]          t_ff;
   logic [65:0]          term_ff;
   logic [63:0]          prod_ff;

   // front-side multiply for squared difference
   logic signed [32:0]   diff;
   logic [32:0]          adiff;
   logic [63:0]          sq_ff;
   logic                 sq_pend_ff;
   logic signed [64:0]   osum_wide;

   logic                 store_wr;
   logic [31:0]          o_rd, s_rd;
   logic [AW-1:0]        rd_addr;

   // divider
   logic                 div_start, div_done;
   logic [DW-1:0]        div_num, div_den, div_q;
   logic [1:0]           div_sel_ff;

   assign smag = osum_ff[63] ? 64'(-osum_ff) : 64'(osum_ff);
   assign diff  = 33'(q_data.observed) - 33'(q_data.simulated);
   assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
   assign osum_wide = 65'(osum_ff) + 65'(q_data.observed);

   // take a queue entry only while loading and no squared term is pending
   assign q_pop   = (state_ff == ST_LOAD) && q_valid && !sq_pend_ff;
   assign store_wr = q_pop && q_data.keep && (n_ff < NW'(MAX_PAIRS));
   assign rd_addr  = idx_ff[AW-1:0];

   mfm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PAIRS)) u_obs_ram (
      .clock(clock), .wr_en(store_wr), .wr_addr(n_ff[AW-1:0]),
      .wr_data(q_data.observed), .rd_addr(rd_addr), .rd_data(o_rd));

   mfm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PAIRS)) u_sim_ram (
      .clock(clock), .wr_en(store_wr), .wr_addr(n_ff[AW-1:0]),
      .wr_data(q_data.simulated), .rd_addr(rd_addr), .rd_data(s_rd));

   mfm_divider #(.WIDTH(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(div_den), .done(div_done), .quotient(div_q));

   // divider operands per phase
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DW'(1);
      unique case (state_ff)
         ST_MEAN: begin
            div_start = (div_sel_ff == 2'd0);
            div_num   = DW'({smag, 1'b0});
            div_den   = DW'(n_ff);
         end
         ST_RMSE_DIV: begin
            div_start = (div_sel_ff == 2'd0);
            div_num   = DW'(sqsum_ff);
            div_den   = DW'(n_ff);
         end
         ST_NRMSE: begin
            // wait for the count product to be registered
            div_start = (div_sel_ff == 2'd1) && (smag != '0);
            div_num   = DW'(prod_ff) << (FRAC_BITS + 1);
            div_den   = DW'(smag);
         end
         ST_D_DIV: begin
            div_start = (div_sel_ff == 2'd0) && (den_ff != '0);
            div_num   = DW'(sqsum_ff) << D_SHIFT;
            div_den   = den_ff;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:
            if (q_pop && q_data.last) state_in = ST_MEAN;
         ST_MEAN:
            if (sq_pend_ff) state_in = ST_MEAN;
            else if (n_ff == '0) state_in = ST_DONE;
            else if (div_done) state_in = ST_RMSE_DIV;
         ST_RMSE_DIV:
            if (div_done) state_in = ST_RMSE_SQRT;
         ST_RMSE_SQRT:
            if (sq_bit_ff == '0) state_in = ST_NRMSE;
         ST_NRMSE:
            if (div_sel_ff == 2'd1 && smag == '0) state_in = ST_PASS;
            else if (div_done) state_in = ST_PASS;
         ST_PASS:
            if (idx_ff == n_ff && !rd_pend_ff && mac_ph_ff == 2'd0) state_in = ST_D_DIV;
         ST_PASS_MAC:
            state_in = ST_PASS;
         ST_D_DIV:
            if (div_sel_ff == 2'd1 && den_ff == '0) state_in = ST_DONE;
            else if (div_done) state_in = ST_DONE;
         ST_DONE:
            state_in = ST_OUT;
         ST_OUT:
            if (!rsp_stall) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid           = (state_ff == ST_OUT);
      rsp_set_id          = treatment_id;
      rsp_valid_count     = COUNT_W'(n_ff);
      rsp_rms_error       = rmse_ff;
      rsp_nrmse_percent   = nrmse_ff;
      rsp_agreement_index = d_ff;
      rsp_status          = (n_ff == '0) ? STATUS_EMPTY :
                            ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
   end

   logic [63:0] t_o, t_s, t_sum, sqt, cand;
   logic [64:0] sq_add;
   logic [DW:0] den_add;
   logic [DW-1:0] qr;

   always_comb begin
      t_o  = (64'(signed'(o_rd)) - mean_ff);
      t_o  = t_o[63] ? -t_o : t_o;
      t_s  = (64'(signed'(s_rd)) - mean_ff);
      t_s  = t_s[63] ? -t_s : t_s;
      t_sum = t_o + t_s;
      cand = 64'(rmse_ff | sq_bit_ff);
      sqt  = cand * cand;
      sq_add  = 65'(sqsum_ff) + 65'(sq_ff);
      den_add = (DW+1)'(den_ff) + (DW+1)'(term_ff);
      qr      = div_q + DW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         n_ff       <= '0;
         osum_ff    <= '0;
         sqsum_ff   <= '0;
         ovf_ff     <= 1'b0;
         sq_pend_ff <= 1'b0;
         div_sel_ff <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         mac_ph_ff  <= '0;
      end else begin
         state_ff <= state_in;
         div_sel_ff <= (state_in != state_ff) ? 2'd0 :
                       (div_sel_ff == 2'd2 ? 2'd2 : div_sel_ff + 2'd1);
         // squared term is added in the cycle after its pair
         if (sq_pend_ff) begin
            sqsum_ff <= sq_add[64] ? '1 : sq_add[63:0];
         end
         sq_pend_ff <= store_wr;
         if (q_pop && q_data.keep) begin
            if (store_wr) begin
               n_ff <= n_ff + 1'b1;
               if (osum_wide[64] != osum_wide[63])
                  osum_ff <= osum_wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
               else
                  osum_ff <= osum_wide[63:0];
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         // second pass: read, form term, multiply, add
         if (state_ff == ST_PASS) begin
            if (idx_ff != n_ff && mac_ph_ff == 2'd0 && !rd_pend_ff) begin
               idx_ff     <= idx_ff + 1'b1;
               rd_pend_ff <= 1'b1;
            end else begin
               rd_pend_ff <= 1'b0;
            end
            if (rd_pend_ff) begin
               t_ff      <= t_sum[32:0];
               mac_ph_ff <= 2'd1;
            end else if (mac_ph_ff == 2'd1) begin
               term_ff   <= t_ff * t_ff;
               mac_ph_ff <= 2'd2;
            end else if (mac_ph_ff == 2'd2) begin
               den_ff    <= den_add[DW-1:0];
               mac_ph_ff <= 2'd0;
            end
         end
         if (state_ff == ST_DONE && state_in == ST_OUT) begin
            idx_ff <= '0;
         end
         if (state_ff == ST_OUT && !rsp_stall) begin
            n_ff     <= '0;
            osum_ff  <= '0;
            sqsum_ff <= '0;
            ovf_ff   <= 1'b0;
            idx_ff   <= '0;
         end
      end
      // datapath registers
      if (state_ff == ST_LOAD && q_pop && q_data.last) begin
         rmse_ff   <= '0;
         nrmse_ff  <= '0;
         d_ff      <= '0;
         den_ff    <= '0;
      end
      if (store_wr) begin
         sq_ff <= 64'(adiff) * 64'(adiff);
      end
      if (state_ff == ST_MEAN && div_done) begin
         mean_ff <= osum_ff[63] ? -64'(signed'((div_q[63:0] + 64'd1) >> 1))
                                : 64'(signed'((div_q[63:0] + 64'd1) >> 1));
      end
      if (state_ff == ST_RMSE_DIV && div_done) begin
         rdiv_ff   <= div_q[63:0];
         sq_bit_ff <= 32'h8000_0000;
      end
      if (state_ff == ST_RMSE_SQRT) begin
         // one result bit per cycle
         if (sqt <= rdiv_ff) rmse_ff <= rmse_ff | sq_bit_ff;
         sq_bit_ff <= sq_bit_ff >> 1;
         prod_ff   <= 64'(rmse_ff) * 64'd100;
      end
      if (state_ff == ST_NRMSE && div_sel_ff == 2'd0) begin
         prod_ff <= prod_ff * 64'(n_ff);
      end
      if (state_ff == ST_NRMSE && div_done) begin
         if (!osum_ff[63]) begin
            nrmse_ff <= (qr[DW-1:32] != '0) ? 32'h7FFF_FFFF : qr[32:1];
         end else begin
            nrmse_ff <= (qr[DW-1:33] != '0 || qr[32:1] > 32'h8000_0000) ?
                        32'h8000_0000 : 32'(-qr[32:1]);
         end
      end
      if (state_ff == ST_D_DIV && div_done) begin
         if (qr[DW-1:1] <= DW'(D_ONE))
            d_ff <= D_ONE - AGREE_W'(qr[DW-1:1]);
         else
            d_ff <= '0;
      end
   end

endmodule
